// ===== rtl/s2l_pkg.sv =====
// Shared types, constants and lookup functions of the solar to lunar date converter.
// Depends on nothing; the datapath, controller and top level import it.
package s2l_pkg;

	// Lunar table size and the lunar year of its first word
	localparam int TABLE_YEARS = 58;
	localparam int BASE_YEAR   = 2020;
	localparam int IDX_W       = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;

	// Day count arithmetic; the year is shifted by one era so nothing goes negative
	localparam int ERA_YEARS    = 400;
	localparam int ERA_DAYS     = 146097;
	localparam int YEAR_MAX     = 4095;
	localparam int ERA_MAX      = (YEAR_MAX + ERA_YEARS) / ERA_YEARS;
	localparam int YY_W         = $clog2(YEAR_MAX + ERA_YEARS + 1);
	localparam int ERA_W        = $clog2(ERA_MAX + 1);
	localparam int YOE_W        = $clog2(ERA_YEARS);
	localparam int DOY_W        = 9;
	localparam int DOE_W        = $clog2(ERA_DAYS + 400);
	localparam int SUM_W        = $clog2((ERA_MAX + 1) * ERA_DAYS);
	// Shifted day count of lunar new year 2020 (2020-01-25)
	localparam int EPOCH_SUM    = 883852;
	localparam int OFF_W        = $clog2(((ERA_MAX + 1) * ERA_DAYS) - EPOCH_SUM);

	// Month and year lengths
	localparam int SHORT_MONTH  = 29;
	localparam int MONTHS       = 12;
	localparam int MONTH_MARCH  = 3;
	localparam int YLEN_W       = 9;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_TABLE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ERA,
		S_YOE,
		S_DOE,
		S_OFFSET,
		S_YEAR,
		S_MONTH,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    load;
		logic    era;
		logic    yoe;
		logic    doe;
		logic    offset;
		logic    year_step;
		logic    month_step;
		logic    set_result;
		status_t code;
	} cmd_t;

	// Status from the datapath back to the controller
	typedef struct packed {
		logic neg;
		logic year_hit;
		logic year_last;
		logic month_hit;
		logic month_last;
	} sts_t;

	// Days before the first of the month, counting from March
	function automatic logic [DOY_W-1:0] month_base(input logic [3:0] mp);
		logic [DOY_W-1:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Lunar year words: leap month in [3:0], long months in [15:4], long leap in [16]
	function automatic logic [16:0] rom_word(input logic [IDX_W-1:0] i);
		logic [16:0] r;
		case (i)
			6'd0:  r = 17'h0a9e4; 6'd1:  r = 17'h05560; 6'd2:  r = 17'h0ab50;
			6'd3:  r = 17'h0ada2; 6'd4:  r = 17'h06d20; 6'd5:  r = 17'h07656;
			6'd6:  r = 17'h07250; 6'd7:  r = 17'h064b0; 6'd8:  r = 17'h06575;
			6'd9:  r = 17'h0cab0; 6'd10: r = 17'h055a0; 6'd11: r = 17'h056e3;
			6'd12: r = 17'h0b690; 6'd13: r = 17'h0f52b; 6'd14: r = 17'h0b520;
			6'd15: r = 17'h0b250; 6'd16: r = 17'h1d0b6; 6'd17: r = 17'h0a4b0;
			6'd18: r = 17'h04ab0; 6'd19: r = 17'h02bb5; 6'd20: r = 17'h05ad0;
			6'd21: r = 17'h0b6a0; 6'd22: r = 17'h0daa2; 6'd23: r = 17'h0d920;
			6'd24: r = 17'h0ea57; 6'd25: r = 17'h0d250; 6'd26: r = 17'h0a550;
			6'd27: r = 17'h1a4d5; 6'd28: r = 17'h04b60; 6'd29: r = 17'h05b50;
			6'd30: r = 17'h16d23; 6'd31: r = 17'h0ec90; 6'd32: r = 17'h0f928;
			6'd33: r = 17'h0e920; 6'd34: r = 17'h0d260; 6'd35: r = 17'h15166;
			6'd36: r = 17'h0a570; 6'd37: r = 17'h05560; 6'd38: r = 17'h13654;
			6'd39: r = 17'h07550; 6'd40: r = 17'h07490; 6'd41: r = 17'h074b3;
			6'd42: r = 17'h06930; 6'd43: r = 17'h0aab7; 6'd44: r = 17'h052b0;
			6'd45: r = 17'h0a5b0; 6'd46: r = 17'h0aba5; 6'd47: r = 17'h056a0;
			6'd48: r = 17'h0b650; 6'd49: r = 17'h0baa4; 6'd50: r = 17'h0b4a0;
			6'd51: r = 17'h0d958; 6'd52: r = 17'h0a950; 6'd53: r = 17'h052d0;
			6'd54: r = 17'h056d6; 6'd55: r = 17'h0ab50; 6'd56: r = 17'h05aa0;
			6'd57: r = 17'h05d54;
			default: r = 17'h00000;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/s2l_in_if.sv =====
// Input channel of the converter: Gregorian date word with valid/ready.
// No dependencies.
interface s2l_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;

	modport source (output valid, year, month, day, input ready);
	modport sink   (input valid, year, month, day, output ready);
endinterface

// ===== rtl/s2l_out_if.sv =====
// Output channel of the converter: lunar date word with status, valid/ready.
// No dependencies.
interface s2l_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] lunar_year;
	logic [3:0]  lunar_month;
	logic        is_leap;
	logic [4:0]  lunar_day;

	modport source (output valid, status, lunar_year, lunar_month, is_leap, lunar_day,
		input ready);
	modport sink   (input valid, status, lunar_year, lunar_month, is_leap, lunar_day,
		output ready);
endinterface

// ===== rtl/s2l_dpath.sv =====
// Datapath: day count, offset from the epoch, year and month walks, result register.
// Depends on s2l_pkg (constants, year word table, month base table).
module s2l_dpath
	import s2l_pkg::*;
(
	input  logic        clk,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	output logic [1:0]  status,
	output logic [11:0] lunar_year,
	output logic [3:0]  lunar_month,
	output logic        is_leap,
	output logic [4:0]  lunar_day
);

	logic [YY_W-1:0]   yy_q;
	logic [3:0]        mp_q;
	logic [4:0]        day_q;
	logic [ERA_W-1:0]  era_q;
	logic [DOY_W-1:0]  base_q;
	logic [YOE_W-1:0]  yoe_q;
	logic [SUM_W-1:0]  prod_q;
	logic [DOE_W-1:0]  doe_q;
	logic [OFF_W-1:0]  off_q;
	logic [IDX_W-1:0]  idx_q;
	logic [3:0]        mm_q;
	logic              leap_ph_q;

	status_t           res_status_q;
	logic [11:0]       res_year_q;
	logic [3:0]        res_month_q;
	logic              res_leap_q;
	logic [4:0]        res_day_q;

	logic              early;
	logic [3:0]        mp_c;
	logic [ERA_W-1:0]  era_c;
	logic [1:0]        cent_c;
	logic [DOE_W-1:0]  doe_c;
	logic [SUM_W-1:0]  sum_c;
	logic [16:0]       word;
	logic [11:0]       mbits;
	logic [3:0]        leap_no;
	logic [3:0]        longs_c;
	logic [YLEN_W-1:0] ylen_c;
	logic [4:0]        mlen_c;

	// Shift March to the front of the year; January and February belong to the year before
	always_comb begin
		early = (month < 4'(MONTH_MARCH));
		mp_c  = early ? (month + 4'(MONTHS - MONTH_MARCH)) : (month - 4'(MONTH_MARCH));
	end

	// Count whole eras in the shifted year
	always_comb begin
		era_c = '0;
		for (int k = 1; k <= ERA_MAX; k++) begin
			if (yy_q >= YY_W'(k * ERA_YEARS))
				era_c = era_c + ERA_W'(1);
		end
	end

	// Day of era from year of era and day of year
	always_comb begin
		cent_c = 2'(yoe_q >= YOE_W'(100)) + 2'(yoe_q >= YOE_W'(200))
			+ 2'(yoe_q >= YOE_W'(300));
		doe_c  = DOE_W'(yoe_q) * DOE_W'(365) + DOE_W'(yoe_q >> 2) - DOE_W'(cent_c)
			+ DOE_W'(base_q) + DOE_W'(day_q);
		sum_c  = prod_q + SUM_W'(doe_q);
	end

	// Year length and month length from the current table word
	always_comb begin
		word    = rom_word(idx_q);
		mbits   = word[15:4];
		leap_no = word[3:0];
		longs_c = '0;
		for (int b = 0; b < MONTHS; b++)
			longs_c = longs_c + 4'(mbits[b]);
		ylen_c  = YLEN_W'(SHORT_MONTH * MONTHS) + YLEN_W'(longs_c);
		if (leap_no != 4'd0)
			ylen_c = ylen_c + YLEN_W'(SHORT_MONTH) + YLEN_W'(word[16]);
		if (leap_ph_q)
			mlen_c = 5'(SHORT_MONTH) + 5'(word[16]);
		else
			mlen_c = 5'(SHORT_MONTH) + 5'(mbits[4'(mm_q - 4'd1)]);
	end

	// Report to the controller
	always_comb begin
		sts.neg        = (sum_c < SUM_W'(EPOCH_SUM));
		sts.year_hit   = (off_q < OFF_W'(ylen_c));
		sts.year_last  = (idx_q == IDX_W'(TABLE_YEARS - 1));
		sts.month_hit  = (off_q < OFF_W'(mlen_c));
		sts.month_last = (mm_q == 4'(MONTHS)) && (leap_ph_q || (leap_no != 4'(MONTHS)));
	end

	// Working registers, advanced one step per command
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			yy_q  <= YY_W'(year) + YY_W'(ERA_YEARS) - YY_W'(early);
			mp_q  <= mp_c;
			day_q <= day;
		end
		if (cmd.era) begin
			era_q  <= era_c;
			base_q <= month_base(mp_q);
		end
		if (cmd.yoe) begin
			yoe_q  <= YOE_W'(yy_q - YY_W'(era_q) * YY_W'(ERA_YEARS));
			prod_q <= SUM_W'(era_q) * SUM_W'(ERA_DAYS);
		end
		if (cmd.doe)
			doe_q <= doe_c;
		if (cmd.offset) begin
			off_q     <= OFF_W'(sum_c - SUM_W'(EPOCH_SUM));
			idx_q     <= '0;
			mm_q      <= 4'd1;
			leap_ph_q <= 1'b0;
		end
		// Drop one lunar year and move to the next word
		if (cmd.year_step && !sts.year_hit) begin
			off_q <= off_q - OFF_W'(ylen_c);
			idx_q <= idx_q + IDX_W'(1);
		end
		// Drop one month; a leap month follows its base month
		if (cmd.month_step && !sts.month_hit) begin
			off_q <= off_q - OFF_W'(mlen_c);
			if (!leap_ph_q && (leap_no == mm_q)) begin
				leap_ph_q <= 1'b1;
			end else begin
				leap_ph_q <= 1'b0;
				mm_q      <= mm_q + 4'd1;
			end
		end
	end

	// Result register; fields are cleared on a failed conversion
	always_ff @(posedge clk) begin
		if (cmd.set_result) begin
			res_status_q <= cmd.code;
			if (cmd.code == ST_OK) begin
				res_year_q  <= 12'(BASE_YEAR) + 12'(idx_q);
				res_month_q <= mm_q;
				res_leap_q  <= leap_ph_q;
				res_day_q   <= 5'(off_q) + 5'd1;
			end else begin
				res_year_q  <= '0;
				res_month_q <= '0;
				res_leap_q  <= 1'b0;
				res_day_q   <= '0;
			end
		end
	end

	assign status      = res_status_q;
	assign lunar_year  = res_year_q;
	assign lunar_month = res_month_q;
	assign is_leap     = res_leap_q;
	assign lunar_day   = res_day_q;

endmodule

// ===== rtl/s2l_ctrl.sv =====
// Controller: sequences one conversion and owns both handshakes.
// Depends on s2l_pkg (state, command and status types).
module s2l_ctrl
	import s2l_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t  state_q, state_d;
	status_t code_q, code_d;
	logic    out_valid_q;

	// State, pending status code and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (cmd.set_result)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		cmd      = '0;
		cmd.code = code_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ERA;
				end
			end
			S_ERA: begin
				cmd.era = 1'b1;
				state_d = S_YOE;
			end
			S_YOE: begin
				cmd.yoe = 1'b1;
				state_d = S_DOE;
			end
			S_DOE: begin
				cmd.doe = 1'b1;
				state_d = S_OFFSET;
			end
			S_OFFSET: begin
				cmd.offset = 1'b1;
				if (sts.neg) begin
					code_d  = ST_RANGE;
					state_d = S_DONE;
				end else begin
					state_d = S_YEAR;
				end
			end
			S_YEAR: begin
				cmd.year_step = 1'b1;
				if (sts.year_hit) begin
					state_d = S_MONTH;
				end else if (sts.year_last) begin
					code_d  = ST_RANGE;
					state_d = S_DONE;
				end
			end
			S_MONTH: begin
				cmd.month_step = 1'b1;
				if (sts.month_hit) begin
					code_d  = ST_OK;
					state_d = S_DONE;
				end else if (sts.month_last) begin
					code_d  = ST_TABLE;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// Hold until the output register is free or being emptied
				if (!out_valid_q || out_ready) begin
					cmd.set_result = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/solar_to_lunar_date_top.sv =====
// Top level of the Gregorian to lunar date converter: controller plus datapath.
// Depends on s2l_pkg, s2l_in_if, s2l_out_if, s2l_ctrl and s2l_dpath.
//
//   channel | dir | word
//   --------+-----+------------------------------------------------------------
//   req     | in  | year[11:0], month[3:0], day[4:0]
//   rsp     | out | status[1:0], lunar_year[11:0], lunar_month[3:0], is_leap,
//           |     | lunar_day[4:0]
//
// One date is converted at a time: load, era, year of era, day of era and epoch offset steps, then
// a walk over the lunar years at one year per cycle (1 to 58 words) and over the months at one month
// per cycle (1 to 13), then the result register is loaded once the output is free. A date before
// the epoch skips both walks; the year walk over the table words makes up most of a long conversion.
// req.ready is high only while idle; a new date is taken while a result still waits.
// Reset (arst_n low) clears the controller and drops any result not yet taken.
module solar_to_lunar_date_top
	import s2l_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	s2l_in_if.sink    req,
	s2l_out_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	s2l_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	s2l_dpath u_dpath (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.year        (req.year),
		.month       (req.month),
		.day         (req.day),
		.status      (rsp.status),
		.lunar_year  (rsp.lunar_year),
		.lunar_month (rsp.lunar_month),
		.is_leap     (rsp.is_leap),
		.lunar_day   (rsp.lunar_day)
	);

	// Busy once a date is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("converter took a second date while busy");

	// Controller issues at most one command per cycle
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.era, cmd.yoe, cmd.doe, cmd.offset, cmd.year_step,
			cmd.month_step, cmd.set_result}))
		else $error("more than one datapath command in a cycle");

	// A successful result holds a real lunar date
	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_OK)) |->
		(rsp.lunar_day != 5'd0) && (rsp.lunar_day <= 5'd30) &&
		(rsp.lunar_month != 4'd0) && (rsp.lunar_month <= 4'(MONTHS)) &&
		(rsp.lunar_year >= 12'(BASE_YEAR)))
		else $error("lunar date out of range on a successful result");

	// A failed result carries cleared fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_OK)) |->
		(rsp.lunar_year == 12'd0) && (rsp.lunar_month == 4'd0) &&
		!rsp.is_leap && (rsp.lunar_day == 5'd0))
		else $error("failed conversion left result fields set");

endmodule
